/* hw/rtl/ctd_pkg.sv */
`default_nettype none
package ctd_pkg;

  localparam int MAX_LEN_DEF  = 64;
  localparam int MAX_COLS_DEF = 8;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 4;
  localparam int CHAR_W     = 8;

  localparam logic [CFG_DATA_W-1:0] KEY_CHARS_RESET  = 64'h0000_0000_0059_454B;
  localparam logic [KEY_LEN_W-1:0]  KEY_LENGTH_RESET = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 4'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_PLACE,
    ST_READ,
    ST_SEND
  } ctd_state_t;

  typedef struct packed {
    logic store;
    logic start;
    logic div_step;
    logic place_step;
    logic read;
    logic advance;
    logic clear;
  } ctd_cmd_t;

  typedef struct packed {
    logic div_last;
    logic place_last;
    logic emit_last;
  } ctd_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/ctd_ctrl.sv */
`default_nettype none
module ctd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              final_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output ctd_pkg::ctd_cmd_t cmd,
  input  ctd_pkg::ctd_sts_t sts
);
  import ctd_pkg::*;

  ctd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (final_byte) begin
            cmd.start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place_step = 1'b1;
        if (sts.place_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/ctd_dpath.sv */
`default_nettype none
module ctd_dpath #(
  parameter int MAX_LEN  = ctd_pkg::MAX_LEN_DEF,
  parameter int MAX_COLS = ctd_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctd_pkg::ctd_cmd_t              cmd,
  output ctd_pkg::ctd_sts_t              sts,
  input  logic                           cfg_we,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ctd_pkg::CHAR_W-1:0]     cipher_byte,
  output logic [ctd_pkg::CHAR_W-1:0]     plain_byte,
  output logic                           last_out,
  output logic                           overflow
);
  import ctd_pkg::*;

  localparam int NW = $clog2(MAX_LEN + 1);   // byte count
  localparam int AW = $clog2(MAX_LEN);       // store address
  localparam int BW = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW = $clog2(MAX_COLS + 1);  // column count
  localparam int RW = $clog2(MAX_COLS);      // column index / rank

  // Configuration
  logic [CFG_DATA_W-1:0] key_chars;
  logic [KEY_LEN_W-1:0]  key_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars  <= KEY_CHARS_RESET;
      key_length <= KEY_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_CHARS:  key_chars  <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp column count to 1..MAX_COLS
  logic [CW-1:0] cols;
  always_comb begin
    if (key_length == '0) begin
      cols = CW'(1);
    end else if (32'(key_length) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(key_length);
    end
  end

  // Column ranks: smaller character first, ties in key order
  logic [CHAR_W-1:0] key [MAX_COLS];
  logic [RW-1:0]     rank [MAX_COLS];

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      key[i] = key_chars[CHAR_W*i +: CHAR_W];
    end
    for (int i = 0; i < MAX_COLS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MAX_COLS; j++) begin
        if ((CW'(j) < cols) &&
            ((key[j] < key[i]) || ((key[j] == key[i]) && (j < i)))) begin
          rank[i] = rank[i] + RW'(1);
        end
      end
    end
  end

  // Message store
  logic [CHAR_W-1:0] mem [MAX_LEN];
  logic [NW-1:0]     byte_count;
  logic              dropped_flag;
  logic              room;

  assign room = (32'(byte_count) < MAX_LEN);

  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[byte_count[AW-1:0]] <= cipher_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      byte_count   <= '0;
      dropped_flag <= 1'b0;
    end else if (cmd.store) begin
      if (room) begin
        byte_count <= byte_count + NW'(1);
      end else begin
        dropped_flag <= 1'b1;
      end
    end
  end

  // Restoring divide: byte_count / cols, one quotient bit a cycle
  logic [NW-1:0] full;
  logic [CW-1:0] rem;
  logic [BW-1:0] div_bit;
  logic [CW:0]   div_trial;

  assign div_trial = {rem, byte_count[div_bit]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem     <= '0;
      div_bit <= BW'(NW - 1);
    end else if (cmd.div_step) begin
      if (div_trial >= {1'b0, cols}) begin
        rem           <= CW'(div_trial - {1'b0, cols});
        full[div_bit] <= 1'b1;
      end else begin
        rem           <= div_trial[CW-1:0];
        full[div_bit] <= 1'b0;
      end
      div_bit <= div_bit - BW'(1);
    end
  end

  // Column start offsets, walked in rank order
  logic [NW-1:0] start [MAX_COLS];
  logic [RW-1:0] place_rank;
  logic [NW-1:0] place_acc;
  logic [NW-1:0] place_height;

  always_comb begin
    place_height = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if ((CW'(i) < cols) && (rank[i] == place_rank)) begin
        place_height = place_height | (full + NW'(CW'(i) < rem));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      place_rank <= '0;
      place_acc  <= '0;
    end else if (cmd.place_step) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        if ((CW'(i) < cols) && (rank[i] == place_rank)) begin
          start[i] <= place_acc;
        end
      end
      place_rank <= place_rank + RW'(1);
      place_acc  <= place_acc + place_height;
    end
  end

  // Emit walk: row by row, left to right
  logic [NW-1:0]     emit_pos;
  logic [NW-1:0]     emit_row;
  logic [RW-1:0]     emit_col;
  logic [NW-1:0]     src;
  logic              col_wrap;
  logic [CHAR_W-1:0] rdata;

  assign src      = start[emit_col] + emit_row;
  assign col_wrap = (CW'(emit_col) == cols - CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      emit_pos <= '0;
      emit_row <= '0;
      emit_col <= '0;
    end else if (cmd.advance) begin
      emit_pos <= emit_pos + NW'(1);
      if (col_wrap) begin
        emit_col <= '0;
        emit_row <= emit_row + NW'(1);
      end else begin
        emit_col <= emit_col + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata <= mem[src[AW-1:0]];
    end
  end

  assign sts.div_last   = (div_bit == '0);
  assign sts.place_last = (CW'(place_rank) == cols - CW'(1));
  assign sts.emit_last  = (emit_pos == byte_count - NW'(1));

  assign plain_byte = rdata;
  assign last_out   = sts.emit_last;
  assign overflow   = dropped_flag;

endmodule
`default_nettype wire

/* hw/rtl/columnar_transposition_decrypt.sv */
`default_nettype none
// Channel  Handshake              Payload                          Direction
// in       in_valid / in_ready    cipher_byte, final_byte          into block
// out      out_valid / out_ready  plain_byte, last_out, overflow   out of block
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data              into block
//
// Loading accepts ciphertext beats back to back. After the final beat the
// block runs the serial divider (row count and remainder), then places the
// column offsets one key column at a time in rank order, then sends each
// plaintext beat as a registered store read followed by an output hold.
// in_ready is low from the final beat until the last plaintext beat is taken;
// out_valid holds with a stable payload while out_ready is low.
// Reset restores the key registers and empties the message; cfg is always ready.
module columnar_transposition_decrypt #(
  parameter int MAX_LEN  = ctd_pkg::MAX_LEN_DEF,
  parameter int MAX_COLS = ctd_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ctd_pkg::CHAR_W-1:0]     cipher_byte,
  input  logic                           final_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ctd_pkg::CHAR_W-1:0]     plain_byte,
  output logic                           last_out,
  output logic                           overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctd_pkg::*;

  ctd_cmd_t cmd;
  ctd_sts_t sts;

  assign cfg_ready = 1'b1;

  ctd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ctd_dpath #(
    .MAX_LEN  (MAX_LEN),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cipher_byte (cipher_byte),
    .plain_byte  (plain_byte),
    .last_out    (last_out),
    .overflow    (overflow)
  );

endmodule
`default_nettype wire

/* tb/ctd_plaintext_checker.sv */
module ctd_plaintext_checker #(
  parameter int MAX_LEN  = ctd_pkg::MAX_LEN_DEF,
  parameter int MAX_COLS = ctd_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [ctd_pkg::CHAR_W-1:0]     cipher_byte,
  input  logic                           final_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ctd_pkg::CHAR_W-1:0]     plain_byte,
  input  logic                           last_out,
  input  logic                           overflow,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] plain;
    logic              last;
    logic              ovf;
  } plain_beat_t;

  plain_beat_t           plain_due[$];
  logic [CFG_DATA_W-1:0] key_chars_q;
  logic [KEY_LEN_W-1:0]  key_len_q;
  logic [CHAR_W-1:0]     msg_store [MAX_LEN];
  int unsigned           msg_count;
  bit                    msg_dropped;

  // Columns are filled in rank order, then the grid is read row by row.
  task automatic decrypt_message();
    int cols;
    int rows;
    int rem;
    int src;
    int rank   [MAX_COLS];
    int height [MAX_COLS];
    int start  [MAX_COLS];
    plain_beat_t beat;
    cols = (key_len_q == 0) ? 1 : (int'(key_len_q) > MAX_COLS) ? MAX_COLS : int'(key_len_q);
    rows = msg_count / cols;
    rem  = msg_count % cols;
    for (int i = 0; i < cols; i++) begin
      rank[i] = 0;
      for (int j = 0; j < cols; j++) begin
        if (key_chars_q[j*8 +: 8] < key_chars_q[i*8 +: 8] ||
            (key_chars_q[j*8 +: 8] == key_chars_q[i*8 +: 8] && j < i)) begin
          rank[i]++;
        end
      end
      height[i] = rows + ((i < rem) ? 1 : 0);
    end
    for (int i = 0; i < cols; i++) begin
      start[i] = 0;
      for (int j = 0; j < cols; j++) begin
        if (rank[j] < rank[i]) begin
          start[i] += height[j];
        end
      end
    end
    for (int p = 0; p < int'(msg_count); p++) begin
      src = start[p % cols] + p / cols;
      beat.plain = msg_store[src];
      beat.last  = (p + 1 == int'(msg_count));
      beat.ovf   = msg_dropped;
      plain_due.push_back(beat);
    end
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    plain_beat_t want;
    if (rst) begin
      key_chars_q = KEY_CHARS_RESET;
      key_len_q   = KEY_LENGTH_RESET;
      msg_count   = 0;
      msg_dropped = 0;
      plain_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_CHARS) begin
          key_chars_q = cfg_data;
        end else if (cfg_index == REG_KEY_LENGTH) begin
          key_len_q = cfg_data[KEY_LEN_W-1:0];
        end
      end
      if (out_valid && out_ready) begin
        if (plain_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected plaintext beat byte %02h last %0d ovf %0d",
                     plain_byte, last_out, overflow);
          end
        end else begin
          want = plain_due.pop_front();
          if (want !== {plain_byte, last_out, overflow}) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("plaintext mismatch: want byte %02h last %0d ovf %0d, got %02h %0d %0d",
                       want.plain, want.last, want.ovf, plain_byte, last_out, overflow);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        // Drop bytes once the store is full, but remember it.
        if (msg_count < MAX_LEN) begin
          msg_store[msg_count] = cipher_byte;
          msg_count++;
        end else begin
          msg_dropped = 1;
        end
        if (final_byte) begin
          decrypt_message();
          msg_count   = 0;
          msg_dropped = 0;
        end
      end
    end
    pending = plain_due.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctd_pkg::*;

  localparam int  RANDOM_ITEMS = 320;
  localparam int  DRAIN_CYCLES = 32;
  localparam int  HOLD_CYCLES  = 400;
  localparam real TIMEOUT_NS   = 3_000_000.0;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  bit                    clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAR_W-1:0]     cipher_byte;
  logic                  final_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_W-1:0]     plain_byte;
  logic                  last_out;
  logic                  overflow;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int burst_left = 0;
  int items_sent = 0;
  bit hold_req   = 1'b0;

  always #4 clk = ~clk;

  columnar_transposition_decrypt dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cipher_byte (cipher_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .plain_byte  (plain_byte),
    .last_out    (last_out),
    .overflow    (overflow),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  ctd_plaintext_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cipher_byte (cipher_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .plain_byte  (plain_byte),
    .last_out    (last_out),
    .overflow    (overflow),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // Offer one ciphertext beat; open a new burst after a random gap.
  task automatic send_beat(input logic [CHAR_W-1:0] b, input logic fin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
    end
    in_valid    <= 1'b1;
    cipher_byte <= b;
    final_byte  <= fin;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_cipher_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_beat(CHAR_W'($urandom_range(1, 255)), i == len - 1);
    end
  endtask

  // Hold the input until every plaintext beat is out and the block is idle.
  task automatic drain_plaintext();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rx_mode_t mode;
    int       run_left;
    out_ready = 1'b0;
    mode      = RX_STREAM;
    run_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        case (mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] key;
    int                    len;
    int                    phase;
    int                    r;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cipher_byte = '0;
    final_byte  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_KEY_CHARS;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key: single-byte message, then one with a zero byte and extremes.
    send_beat(8'hFF, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7F, 1'b1);
    drain_plaintext();

    // Zero key length acts as a single column.
    write_reg(REG_KEY_LENGTH, CFG_DATA_W'(0));
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hC3, 1'b1);
    drain_plaintext();

    // Oversized length clamps to the column limit; all-zero key ranks by position.
    write_reg(REG_KEY_CHARS, '0);
    write_reg(REG_KEY_LENGTH, CFG_DATA_W'(15));
    for (int i = 0; i < 9; i++) begin
      send_beat(CHAR_W'(i * 29 + 1), i == 8);
    end
    drain_plaintext();

    // Descending key: rank order is the reverse of key order.
    write_reg(REG_KEY_CHARS, 64'h0001_0203_0405_0607);
    write_reg(REG_KEY_LENGTH, CFG_DATA_W'(8));
    for (int i = 0; i < 8; i++) begin
      send_beat(CHAR_W'(8'hF0 + i), i == 7);
    end

    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain_plaintext();
      case (phase % 6)
        0: begin
          key = '1;
          len = 8;
        end
        1: begin
          key = {$urandom, $urandom};
          len = 1;
        end
        2: begin
          // Few distinct characters force plenty of ties.
          for (int k = 0; k < 8; k++) begin
            key[k*8 +: 8] = 8'($urandom_range(65, 68));
          end
          len = $urandom_range(2, 8);
        end
        3: begin
          key = {$urandom, $urandom};
          len = $urandom_range(0, 15);
        end
        4: begin
          key = '0;
          len = 8;
        end
        default: begin
          key = {$urandom, $urandom};
          len = $urandom_range(1, 8);
        end
      endcase
      write_reg(REG_KEY_CHARS, key);
      write_reg(REG_KEY_LENGTH, CFG_DATA_W'(len));

      if (phase == 2) begin
        // Stall the output long enough for the input to back up.
        hold_req = 1'b1;
        send_cipher_message(48);
        send_cipher_message(12);
      end
      if (phase == 3) begin
        send_cipher_message(64);
        send_cipher_message(65);
      end
      if (phase == 5) begin
        send_cipher_message(72);
      end
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          len = $urandom_range(65, 72);
        end else if (r < 3) begin
          len = $urandom_range(17, 64);
        end else begin
          len = $urandom_range(1, 16);
        end
        send_cipher_message(len);
      end
      phase++;
    end
    drain_plaintext();

    if (mismatches == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ctd_pkg.sv
hw/rtl/ctd_ctrl.sv
hw/rtl/ctd_dpath.sv
hw/rtl/columnar_transposition_decrypt.sv
tb/ctd_plaintext_checker.sv
tb/tb.sv
